// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/gdc_pkg.sv -----
package gdc_pkg;

  // Payload widths
  localparam int VEC_W  = 16;
  localparam int DIFF_W = VEC_W + 1;
  localparam int PROD_W = 34;
  localparam int RES_W  = 36;
  localparam int SIZE_W = 7;
  localparam int IDX_W  = 6;

  // Input kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_INV_CELL_X  = 2'd2;
  localparam logic [1:0] CFG_INV_CELL_Y  = 2'd3;

  // Configuration reset values
  localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 7'd64;
  localparam logic [VEC_W-1:0]  INV_CELL_RST  = 16'd256;
  localparam logic [SIZE_W-1:0] GRID_SIZE_MIN = 7'd2;

  // Sequencer steps of one query
  localparam logic [2:0] STEP_RD_XHI  = 3'd0;
  localparam logic [2:0] STEP_RD_XLO  = 3'd1;
  localparam logic [2:0] STEP_MUL_DXX = 3'd2;
  localparam logic [2:0] STEP_MUL_DYX = 3'd3;
  localparam logic [2:0] STEP_MUL_DYY = 3'd4;
  localparam logic [2:0] STEP_MUL_DXY = 3'd5;
  localparam logic [2:0] STEP_DRAIN   = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_DIV,
    ACC_CURL_ADD,
    ACC_CURL_SUB
  } acc_op_t;

endpackage

// ----- design/grid_divergence_curl.sv -----
// Channel   Handshake              Payload
// input     start / busy           in_kind, in_col, in_row, in_vec_x, in_vec_y
// result    out_valid (strobe)     out_divergence, out_curl_value, out_out_of_range
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A write transaction is taken at once; busy stays low and writes may follow back to back.
// A query keeps busy high until it strobes its result, and no new item is taken
// meanwhile: four reads through the single-port field memory feed
// one shared multiplier, one product per cycle. A query outside the grid ends without reads.
// rst_n is synchronous and active low; the field memory is not cleared.
// The receiver cannot stall: the result is shown for exactly one cycle.
module grid_divergence_curl #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [5:0]  in_col,
  input  logic [5:0]  in_row,
  input  logic signed [15:0] in_vec_x,
  input  logic signed [15:0] in_vec_y,
  output logic        out_valid,
  output logic signed [35:0] out_divergence,
  output logic signed [35:0] out_curl_value,
  output logic        out_out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  gdc_pkg::state_t  state_r, state_nxt;
  logic [2:0]       step_r;

  logic [gdc_pkg::SIZE_W-1:0] grid_w_r, grid_h_r;
  logic [gdc_pkg::VEC_W-1:0]  inv_x_r, inv_y_r;

  logic [gdc_pkg::IDX_W-1:0] col_r, row_r;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;
  logic [31:0] hold_r;
  logic signed [gdc_pkg::DIFF_W-1:0] dsave_r;
  logic signed [gdc_pkg::PROD_W-1:0] prod_r;
  gdc_pkg::acc_op_t acc_op_r;
  logic             half_r;
  logic signed [gdc_pkg::RES_W-1:0] div_acc_r, curl_acc_r;
  logic             oor_r;

  logic [gdc_pkg::SIZE_W-1:0] w_eff, h_eff, c7, r7, ch, cl, rh, rl;
  logic        c_first, c_last, r_first, r_last, x_int, y_int, oor_q;
  logic        accept, q_accept, wr_en, rd_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic signed [gdc_pkg::DIFF_W-1:0] diff_x, diff_y, mul_a;
  logic [gdc_pkg::VEC_W-1:0]  mul_b;
  logic signed [gdc_pkg::PROD_W-1:0] mul_p, term;
  logic signed [gdc_pkg::RES_W-1:0]  term_ext;
  logic        mul_half;
  gdc_pkg::acc_op_t mul_op;

  function automatic logic [AW-1:0] cell_addr(logic [gdc_pkg::SIZE_W-1:0] cc,
                                              logic [gdc_pkg::SIZE_W-1:0] rr);
    return AW'(int'(rr) * MAX_COLS + int'(cc));
  endfunction

  assign accept   = start && !busy;
  assign q_accept = accept && (in_kind == gdc_pkg::KIND_QUERY);
  assign wr_en    = accept && (in_kind == gdc_pkg::KIND_WRITE) &&
                    (int'(in_col) < MAX_COLS) && (int'(in_row) < MAX_ROWS);
  assign wr_addr  = cell_addr({1'b0, in_col}, {1'b0, in_row});

  // Clamp the grid size in use to at least GRID_SIZE_MIN and at most the store bounds
  always_comb begin
    if (grid_w_r < gdc_pkg::GRID_SIZE_MIN) begin
      w_eff = gdc_pkg::GRID_SIZE_MIN;
    end else if (int'(grid_w_r) > MAX_COLS) begin
      w_eff = gdc_pkg::SIZE_W'(MAX_COLS);
    end else begin
      w_eff = grid_w_r;
    end
    if (grid_h_r < gdc_pkg::GRID_SIZE_MIN) begin
      h_eff = gdc_pkg::GRID_SIZE_MIN;
    end else if (int'(grid_h_r) > MAX_ROWS) begin
      h_eff = gdc_pkg::SIZE_W'(MAX_ROWS);
    end else begin
      h_eff = grid_h_r;
    end
  end

  // Pick the stencil neighbours: one-sided at the edges, central inside
  always_comb begin
    c7      = {1'b0, col_r};
    r7      = {1'b0, row_r};
    oor_q   = (c7 >= w_eff) || (r7 >= h_eff);
    c_first = (c7 == '0);
    c_last  = (c7 == w_eff - 7'd1);
    r_first = (r7 == '0);
    r_last  = (r7 == h_eff - 7'd1);
    x_int   = !c_first && !c_last;
    y_int   = !r_first && !r_last;
    ch      = c_last  ? c7 : c7 + 7'd1;
    cl      = c_first ? c7 : c7 - 7'd1;
    rh      = r_last  ? r7 : r7 + 7'd1;
    rl      = r_first ? r7 : r7 - 7'd1;
  end

  // Issue one neighbour read per step until all four neighbours are read
  always_comb begin
    rd_en = (state_r == gdc_pkg::ST_RUN) && !oor_q;
    case (step_r)
      gdc_pkg::STEP_RD_XHI:  rd_addr = cell_addr(ch, r7);
      gdc_pkg::STEP_RD_XLO:  rd_addr = cell_addr(cl, r7);
      gdc_pkg::STEP_MUL_DXX: rd_addr = cell_addr(c7, rh);
      gdc_pkg::STEP_MUL_DYX: rd_addr = cell_addr(c7, rl);
      default: begin
        rd_addr = cell_addr(c7, r7);
        rd_en   = 1'b0;
      end
    endcase
  end

  // Field memory, single port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_vec_y, in_vec_x};
    end else if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Differences of the pair just read
  assign diff_x = $signed({hold_r[15], hold_r[15:0]}) - $signed({rd_data_r[15], rd_data_r[15:0]});
  assign diff_y = $signed({hold_r[31], hold_r[31:16]}) -
                  $signed({rd_data_r[31], rd_data_r[31:16]});

  // Select the operands of the shared multiplier
  always_comb begin
    case (step_r)
      gdc_pkg::STEP_MUL_DXX: begin
        mul_a = diff_x;  mul_b = inv_x_r; mul_half = x_int; mul_op = gdc_pkg::ACC_DIV;
      end
      gdc_pkg::STEP_MUL_DYX: begin
        mul_a = dsave_r; mul_b = inv_x_r; mul_half = x_int; mul_op = gdc_pkg::ACC_CURL_ADD;
      end
      gdc_pkg::STEP_MUL_DYY: begin
        mul_a = diff_y;  mul_b = inv_y_r; mul_half = y_int; mul_op = gdc_pkg::ACC_DIV;
      end
      gdc_pkg::STEP_MUL_DXY: begin
        mul_a = dsave_r; mul_b = inv_y_r; mul_half = y_int; mul_op = gdc_pkg::ACC_CURL_SUB;
      end
      default: begin
        mul_a = '0;      mul_b = '0;      mul_half = 1'b0;  mul_op = gdc_pkg::ACC_NONE;
      end
    endcase
    if (state_r != gdc_pkg::ST_RUN || oor_q) begin
      mul_op = gdc_pkg::ACC_NONE;
    end
  end

  assign mul_p    = mul_a * $signed({1'b0, mul_b});
  assign term     = half_r ? (prod_r >>> 1) : prod_r;
  assign term_ext = {{(gdc_pkg::RES_W - gdc_pkg::PROD_W){term[gdc_pkg::PROD_W-1]}}, term};

  // Datapath: hold pairs, register products, accumulate
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= in_col;
      row_r <= in_row;
    end
    if (step_r == gdc_pkg::STEP_RD_XLO || step_r == gdc_pkg::STEP_MUL_DYX) begin
      hold_r <= rd_data_r;
    end
    if (step_r == gdc_pkg::STEP_MUL_DXX) begin
      dsave_r <= diff_y;
    end else if (step_r == gdc_pkg::STEP_MUL_DYY) begin
      dsave_r <= diff_x;
    end
    prod_r <= mul_p;
    half_r <= mul_half;
  end

  // Accumulators and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gdc_pkg::ST_IDLE;
      step_r     <= gdc_pkg::STEP_RD_XHI;
      acc_op_r   <= gdc_pkg::ACC_NONE;
      oor_r      <= 1'b0;
      div_acc_r  <= '0;
      curl_acc_r <= '0;
      grid_w_r   <= gdc_pkg::GRID_SIZE_RST;
      grid_h_r   <= gdc_pkg::GRID_SIZE_RST;
      inv_x_r    <= gdc_pkg::INV_CELL_RST;
      inv_y_r    <= gdc_pkg::INV_CELL_RST;
    end else begin
      state_r  <= state_nxt;
      acc_op_r <= mul_op;
      if (state_r == gdc_pkg::ST_RUN) begin
        step_r <= step_r + 3'd1;
        oor_r  <= oor_q;
      end else begin
        step_r <= gdc_pkg::STEP_RD_XHI;
      end
      if (q_accept) begin
        div_acc_r  <= '0;
        curl_acc_r <= '0;
        oor_r      <= 1'b0;
      end else begin
        case (acc_op_r)
          gdc_pkg::ACC_DIV:      div_acc_r  <= div_acc_r + term_ext;
          gdc_pkg::ACC_CURL_ADD: curl_acc_r <= curl_acc_r + term_ext;
          gdc_pkg::ACC_CURL_SUB: curl_acc_r <= curl_acc_r - term_ext;
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gdc_pkg::CFG_GRID_WIDTH:  grid_w_r <= cfg_data[gdc_pkg::SIZE_W-1:0];
          gdc_pkg::CFG_GRID_HEIGHT: grid_h_r <= cfg_data[gdc_pkg::SIZE_W-1:0];
          gdc_pkg::CFG_INV_CELL_X:  inv_x_r  <= cfg_data;
          gdc_pkg::CFG_INV_CELL_Y:  inv_y_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdc_pkg::ST_IDLE: begin
        if (q_accept) begin
          state_nxt = gdc_pkg::ST_RUN;
        end
      end
      gdc_pkg::ST_RUN: begin
        if (oor_q || step_r == gdc_pkg::STEP_DRAIN) begin
          state_nxt = gdc_pkg::ST_DONE;
        end
      end
      gdc_pkg::ST_DONE: state_nxt = gdc_pkg::ST_IDLE;
      default:          state_nxt = gdc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy             = (state_r != gdc_pkg::ST_IDLE);
    out_valid        = (state_r == gdc_pkg::ST_DONE);
    out_divergence   = div_acc_r;
    out_curl_value   = curl_acc_r;
    out_out_of_range = oor_r;
    cfg_ready        = 1'b1;
  end

endmodule

// ----- design/gdc_checker.sv -----
`include "assert_macros.svh"

module gdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_kind,
  input logic        out_valid,
  input logic signed [35:0] out_divergence,
  input logic signed [35:0] out_curl_value,
  input logic        out_out_of_range
);

  // A query transaction makes the block busy
  `ASSERT_NEXT(a_query_busy, start && !busy && in_kind == gdc_pkg::KIND_QUERY, busy, "query did not raise busy")
  // A write transaction yields no result and leaves the block ready
  `ASSERT_NEXT(a_write_quiet, start && !busy && in_kind == gdc_pkg::KIND_WRITE, !busy && !out_valid, "write produced a result or busy")
  // A result outside the grid carries zeros
  `ASSERT_SAME(a_oor_zero, out_valid && out_out_of_range, out_divergence == '0 && out_curl_value == '0, "out of range result not zero")
  // The strobe ends the query
  `ASSERT_NEXT(a_done_idle, out_valid, !busy && !out_valid, "block stayed busy after result")

endmodule

bind grid_divergence_curl gdc_checker u_gdc_checker (.*);

// ----- tb/grid_divergence_curl_tb.sv -----
`timescale 1ns / 100ps

module grid_divergence_curl_tb;

  localparam int GRID_COLS    = 64;
  localparam int GRID_ROWS    = 64;
  localparam int ITEM_TARGET  = 1650;
  localparam int PHASE_ITEMS  = 60;
  // A query holds busy until its strobe; leave margin past the last strobe
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic signed [35:0] div;
    logic signed [35:0] crl;
    logic               oor;
  } field_result_t;

  typedef enum {DO_ITEM, DO_CFG} dir_op_t;

  typedef struct {
    dir_op_t       op;
    logic          kind;
    int            col;
    int            row;
    logic [15:0]   vx;
    logic [15:0]   vy;
    logic [1:0]    reg_idx;
    logic [15:0]   reg_val;
    bit            typed;
    field_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = gdc_pkg::KIND_WRITE;
  logic [5:0]  in_col = '0;
  logic [5:0]  in_row = '0;
  logic [15:0] in_vec_x = '0;
  logic [15:0] in_vec_y = '0;
  logic        out_valid;
  logic signed [35:0] out_divergence;
  logic signed [35:0] out_curl_value;
  logic        out_out_of_range;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow of the block's state and registers
  logic [31:0] field_mem [GRID_COLS*GRID_ROWS];
  bit          written_map [GRID_COLS*GRID_ROWS];
  logic [6:0]  grid_w_reg = gdc_pkg::GRID_SIZE_RST;
  logic [6:0]  grid_h_reg = gdc_pkg::GRID_SIZE_RST;
  logic [15:0] inv_x_reg = gdc_pkg::INV_CELL_RST;
  logic [15:0] inv_y_reg = gdc_pkg::INV_CELL_RST;

  field_result_t expected_fields[$];
  field_result_t oldest;
  field_result_t no_result = '{default: '0};
  dir_row_t      dir_rows[$];
  int  mismatch_count = 0;
  int  items_sent = 0;
  bit  gap_free = 1'b0;

  grid_divergence_curl uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_col           (in_col),
    .in_row           (in_row),
    .in_vec_x         (in_vec_x),
    .in_vec_y         (in_vec_y),
    .out_valid        (out_valid),
    .out_divergence   (out_divergence),
    .out_curl_value   (out_curl_value),
    .out_out_of_range (out_out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a size register to the range the grid supports
  function automatic int eff_size(input logic [6:0] v, input int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int lo16(input logic [31:0] w);
    return int'($signed(w[15:0]));
  endfunction

  function automatic int hi16(input logic [31:0] w);
    return int'($signed(w[31:16]));
  endfunction

  // Center, left, right, down, up neighbors of a point, clamped at the edges
  function automatic void stencil_cells(input int c, input int r,
                                        output int cols[5], output int rows[5]);
    int w, h;
    w = eff_size(grid_w_reg, GRID_COLS);
    h = eff_size(grid_h_reg, GRID_ROWS);
    cols = '{c, (c > 0) ? c - 1 : c, (c + 1 < w) ? c + 1 : c, c, c};
    rows = '{r, r, r, (r > 0) ? r - 1 : r, (r + 1 < h) ? r + 1 : r};
  endfunction

  // One-sided difference at an edge, halved central difference inside
  function automatic longint axis_term(input int pos, input int n, input int lo,
                                       input int mid, input int hi, input int inv);
    longint prod;
    if (pos == 0) return longint'(hi - mid) * inv;
    if (pos == n - 1) return longint'(mid - lo) * inv;
    prod = longint'(hi - lo) * inv;
    return prod >>> 1;
  endfunction

  function automatic field_result_t predict_div_curl(input int c, input int r);
    field_result_t res;
    int w, h;
    int cols[5], rows[5];
    logic [31:0] v[5];
    longint dxx, dyx, dyy, dxy;
    w = eff_size(grid_w_reg, GRID_COLS);
    h = eff_size(grid_h_reg, GRID_ROWS);
    if (c >= w || r >= h) begin
      res.div = '0;
      res.crl = '0;
      res.oor = 1'b1;
      return res;
    end
    stencil_cells(c, r, cols, rows);
    foreach (v[i]) v[i] = field_mem[rows[i]*GRID_COLS + cols[i]];
    dxx = axis_term(c, w, lo16(v[1]), lo16(v[0]), lo16(v[2]), int'(inv_x_reg));
    dyx = axis_term(c, w, hi16(v[1]), hi16(v[0]), hi16(v[2]), int'(inv_x_reg));
    dyy = axis_term(r, h, hi16(v[3]), hi16(v[0]), hi16(v[4]), int'(inv_y_reg));
    dxy = axis_term(r, h, lo16(v[3]), lo16(v[0]), lo16(v[4]), int'(inv_y_reg));
    res.div = 36'(dxx + dyy);
    res.crl = 36'(dyx - dxy);
    res.oor = 1'b0;
    return res;
  endfunction

  function automatic logic [15:0] rand_vec();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd64;
      4: return 7'd127;
      5: return 7'($urandom_range(65, 127));
      6: return 7'($urandom_range(3, 63));
      default: return 7'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [15:0] pick_inv();
    case ($urandom_range(0, 6))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd256;
      3: return 16'd1;
      4: return 16'($urandom_range(1, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dir_row_t wr_row(input int c, input int r,
                                      input logic [15:0] vx, input logic [15:0] vy);
    dir_row_t d;
    d = '{op: DO_ITEM, kind: gdc_pkg::KIND_WRITE, col: c, row: r, vx: vx, vy: vy,
          reg_idx: '0, reg_val: '0, typed: 1'b0, want: '{default: '0}};
    return d;
  endfunction

  function automatic dir_row_t q_row(input int c, input int r, input bit typed,
                                     input longint div, input longint crl, input bit oor);
    dir_row_t d;
    d = '{op: DO_ITEM, kind: gdc_pkg::KIND_QUERY, col: c, row: r, vx: '0, vy: '0,
          reg_idx: '0, reg_val: '0, typed: typed, want: '{36'(div), 36'(crl), oor}};
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
    dir_row_t d;
    d = '{op: DO_CFG, kind: gdc_pkg::KIND_WRITE, col: 0, row: 0, vx: '0, vy: '0,
          reg_idx: idx, reg_val: val, typed: 1'b0, want: '{default: '0}};
    return d;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input dir_row_t d);
    dir_rows = {dir_rows, d};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Present one transaction after a random gap and hold it until accepted
  task automatic issue_item(input logic kind, input int c, input int r,
                            input logic [15:0] vx, input logic [15:0] vy,
                            input bit typed, input field_result_t typed_res);
    int gap;
    field_result_t res;
    gap = gap_free ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_col   <= c[5:0];
    in_row   <= r[5:0];
    in_vec_x <= vx;
    in_vec_y <= vy;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (kind == gdc_pkg::KIND_WRITE) begin
      field_mem[r*GRID_COLS + c] = {vy, vx};
      written_map[r*GRID_COLS + c] = 1'b1;
    end else begin
      res = typed ? typed_res : predict_div_curl(c, r);
      expected_fields = {expected_fields, res};
    end
  endtask

  // Hold the sender until every result is back and the block has settled
  task automatic drain_results();
    start <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gdc_pkg::CFG_GRID_WIDTH:  grid_w_reg = val[6:0];
      gdc_pkg::CFG_GRID_HEIGHT: grid_h_reg = val[6:0];
      gdc_pkg::CFG_INV_CELL_X:  inv_x_reg  = val;
      gdc_pkg::CFG_INV_CELL_Y:  inv_y_reg  = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Make sure the stencil is written (refreshing some of it), then query
  task automatic query_in_grid(input int c, input int r);
    int cols[5], rows[5];
    stencil_cells(c, r, cols, rows);
    foreach (cols[i]) begin
      if (!written_map[rows[i]*GRID_COLS + cols[i]] || $urandom_range(0, 3) == 0)
        issue_item(gdc_pkg::KIND_WRITE, cols[i], rows[i], rand_vec(), rand_vec(),
                   1'b0, no_result);
    end
    issue_item(gdc_pkg::KIND_QUERY, c, r, rand_vec(), rand_vec(), 1'b0, no_result);
  endtask

  // Compare each strobed result with the oldest outstanding query
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_fields.size() == 0) begin
        report_mismatch("result strobed with no query outstanding");
      end else begin
        oldest = expected_fields.pop_front();
        if (out_divergence !== oldest.div)
          report_mismatch($sformatf("divergence got %0d want %0d",
                                    out_divergence, oldest.div));
        if (out_curl_value !== oldest.crl)
          report_mismatch($sformatf("curl_value got %0d want %0d",
                                    out_curl_value, oldest.crl));
        if (out_out_of_range !== oldest.oor)
          report_mismatch($sformatf("out_of_range got %0b want %0b",
                                    out_out_of_range, oldest.oor));
      end
    end
  end

  initial begin
    int w_eff, h_eff, c, r, pick;

    // Extremes at the first corner, the last corner, and an interior point
    add_row(wr_row(0, 0, 16'h8000, 16'h8000));
    add_row(wr_row(1, 0, 16'h7FFF, 16'h7FFF));
    add_row(wr_row(0, 1, 16'h7FFF, 16'h7FFF));
    add_row(q_row(0, 0, 1'b1, 64'sd33553920, 64'sd0, 1'b0));
    add_row(wr_row(63, 63, 16'h8000, 16'h7FFF));
    add_row(wr_row(62, 63, 16'h8000, 16'h8000));
    add_row(wr_row(63, 62, 16'h7FFF, 16'h7FFF));
    add_row(q_row(63, 63, 1'b1, 64'sd0, 64'sd33553920, 1'b0));
    add_row(wr_row(1, 1, 16'h1234, 16'hFFFB));
    add_row(wr_row(2, 1, 16'hFFF9, 16'h0101));
    add_row(wr_row(1, 2, 16'h0005, 16'h8000));
    add_row(q_row(1, 1, 1'b0, 0, 0, 1'b0));
    // Sizes below two act as two; junk above bit 6 is dropped
    add_row(cfg_row(gdc_pkg::CFG_GRID_WIDTH, 16'hFF81));
    add_row(cfg_row(gdc_pkg::CFG_GRID_HEIGHT, 16'h0000));
    add_row(cfg_row(gdc_pkg::CFG_INV_CELL_X, 16'hFFFF));
    add_row(cfg_row(gdc_pkg::CFG_INV_CELL_Y, 16'hFFFF));
    add_row(q_row(0, 0, 1'b1, 64'sd8589672450, 64'sd0, 1'b0));
    add_row(q_row(1, 1, 1'b0, 0, 0, 1'b0));
    add_row(q_row(2, 0, 1'b1, 64'sd0, 64'sd0, 1'b1));
    add_row(q_row(0, 2, 1'b1, 64'sd0, 64'sd0, 1'b1));
    add_row(q_row(63, 63, 1'b1, 64'sd0, 64'sd0, 1'b1));
    // Oversized width clamps to the store; odd inverse size exercises rounding
    add_row(cfg_row(gdc_pkg::CFG_GRID_WIDTH, 16'h807F));
    add_row(cfg_row(gdc_pkg::CFG_GRID_HEIGHT, 16'h7F40));
    add_row(cfg_row(gdc_pkg::CFG_INV_CELL_X, 16'h0000));
    add_row(cfg_row(gdc_pkg::CFG_INV_CELL_Y, 16'h0001));
    add_row(q_row(1, 1, 1'b0, 0, 0, 1'b0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == DO_CFG) begin
        drain_results();
        program_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        issue_item(dir_rows[i].kind, dir_rows[i].col, dir_rows[i].row,
                   dir_rows[i].vx, dir_rows[i].vy, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each with its own register setting
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      program_reg(gdc_pkg::CFG_GRID_WIDTH, {9'($urandom), pick_size()});
      program_reg(gdc_pkg::CFG_GRID_HEIGHT, {9'($urandom), pick_size()});
      program_reg(gdc_pkg::CFG_INV_CELL_X, pick_inv());
      program_reg(gdc_pkg::CFG_INV_CELL_Y, pick_inv());
      gap_free = ($urandom_range(0, 3) == 0);
      w_eff = eff_size(grid_w_reg, GRID_COLS);
      h_eff = eff_size(grid_h_reg, GRID_ROWS);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) drain_results();
        if (pick < 70) begin
          query_in_grid($urandom_range(0, w_eff - 1), $urandom_range(0, h_eff - 1));
        end else if (pick < 82 && (w_eff < GRID_COLS || h_eff < GRID_ROWS)) begin
          if (w_eff < GRID_COLS && (h_eff == GRID_ROWS || $urandom_range(0, 1) == 1)) begin
            c = $urandom_range(w_eff, GRID_COLS - 1);
            r = $urandom_range(0, GRID_ROWS - 1);
          end else begin
            c = $urandom_range(0, GRID_COLS - 1);
            r = $urandom_range(h_eff, GRID_ROWS - 1);
          end
          issue_item(gdc_pkg::KIND_QUERY, c, r, rand_vec(), rand_vec(), 1'b0, no_result);
        end else begin
          issue_item(gdc_pkg::KIND_WRITE, $urandom_range(0, GRID_COLS - 1),
                     $urandom_range(0, GRID_ROWS - 1), rand_vec(), rand_vec(),
                     1'b0, no_result);
        end
      end
    end

    drain_results();
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
